// ===== design/histogram_bin_incrementer_defines.svh =====
// ----------------------------------------------------------------------------
// Histogram bin incrementer assertion macros
// Shared concurrent assertion forms for the histogram bin incrementer.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_BIN_INCREMENTER_DEFINES_SVH
`define HISTOGRAM_BIN_INCREMENTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HBI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define HBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram bin incrementer package
// Field widths, outcome and register codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package hbi_pkg;

  // Field widths.
  localparam int CH_W       = 18;
  localparam int MAG_W      = 17;
  localparam int CNT_W      = 32;
  localparam int OUTCOME_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int BIU_W      = 11;

  // Reset value of the bins-in-use register.
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  // Outcome of one item.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_IGNORED = 2'd0,
    OUT_BIN     = 2'd1,
    OUT_UNDER   = 2'd2,
    OUT_OVER    = 2'd3
  } outcome_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALL_BOUND   = 1'd0,
    CFG_BINS_IN_USE = 1'd1
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;   // write zero to the next bin of the clearing pass
    logic item_load;  // capture the accepted item and its outcome
    logic rd_en;      // read the addressed bin
    logic update;     // write back, bump counters, load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last; // clearing pass is at its last bin
  } dp_status_t;

endpackage

// ===== design/histogram_bin_incrementer.sv =====
// ----------------------------------------------------------------------------
// Histogram bin incrementer
// Counting histogram engine with underflow and overflow counters.
// ----------------------------------------------------------------------------
// Each accepted item passes through capture and classify, read of the bin
// store, and write-back of the bumped count together with the counter update,
// which waits while a pending result is not taken; the read-modify-write runs
// through the registered-read bin store. A finished result waits in an
// output register, so the next item is taken while it is still pending.
// After reset the bin store is zeroed by a clearing pass over every bin, during
// which no item is accepted; configuration writes are taken at any time.
// Configuration index 0 is all_bound (data bit 0), index 1 is bins_in_use
// (data bits 10:0), which saturates at BINS.
module histogram_bin_incrementer #(
  parameter int BINS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_value_valid,
  input  logic signed [hbi_pkg::CH_W-1:0]   in_channel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hbi_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [hbi_pkg::CNT_W-1:0]         out_bin_count,
  output logic [hbi_pkg::CNT_W-1:0]         out_underflow_total,
  output logic [hbi_pkg::CNT_W-1:0]         out_overflow_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbi_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import hbi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  hbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  hbi_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_value_valid      (in_value_valid),
    .in_channel          (in_channel),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_outcome         (out_outcome),
    .out_bin_count       (out_bin_count),
    .out_underflow_total (out_underflow_total),
    .out_overflow_total  (out_overflow_total)
  );

endmodule

// ===== design/hbi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/hbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Histogram bin incrementer controller
// Sequences the clearing pass and the read-modify-write of each item.
// ----------------------------------------------------------------------------
`include "histogram_bin_incrementer_defines.svh"

module hbi_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hbi_pkg::ctrl_cmd_t     cmd,
  input  hbi_pkg::dp_status_t    status
);

  import hbi_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Result valid: set when a result is loaded, cleared when it transfers.
  always_comb begin
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A pending result is never overwritten.
  `HBI_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.update, (!out_valid_r || out_ready), "result register overwritten while a result is pending")
  // Every captured item is followed by its bin read.
  `HBI_ASSERT_NEXT(a_load_then_read, clk, rst_n, cmd.item_load, cmd.rd_en, "bin read did not follow item capture")
  // A loaded result is presented in the next cycle.
  `HBI_ASSERT_NEXT(a_update_shows, clk, rst_n, cmd.update, out_valid, "result not presented after update")
  // No item is taken during the clearing pass.
  `HBI_ASSERT_SAME(a_no_take_in_clear, clk, rst_n, cmd.clear_wr, !in_ready && !cmd.update, "item activity during clearing pass")

endmodule

// ===== design/hbi_dp.sv =====
// ----------------------------------------------------------------------------
// Histogram bin incrementer datapath
// Configuration registers, item classification, bin store and counters.
// ----------------------------------------------------------------------------
module hbi_dp #(
  parameter int BINS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hbi_pkg::ctrl_cmd_t                cmd,
  output hbi_pkg::dp_status_t               status,
  input  logic                              in_value_valid,
  input  logic signed [hbi_pkg::CH_W-1:0]   in_channel,
  input  logic                              cfg_valid,
  input  logic [hbi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbi_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [hbi_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [hbi_pkg::CNT_W-1:0]         out_bin_count,
  output logic [hbi_pkg::CNT_W-1:0]         out_underflow_total,
  output logic [hbi_pkg::CNT_W-1:0]         out_overflow_total
);

  import hbi_pkg::*;

  localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [MAG_W-1:0] BINS_MAG  = MAG_W'(BINS);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(BINS - 1);

  logic                 all_bound_r;
  logic [BIU_W-1:0]     bins_in_use_r;
  outcome_t             item_outcome_r;
  logic [AW-1:0]        item_addr_r;
  logic [AW-1:0]        clr_addr_r;
  logic [CNT_W-1:0]     underflow_r, underflow_nxt;
  logic [CNT_W-1:0]     overflow_r, overflow_nxt;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [CNT_W-1:0]     out_bin_count_r;
  logic [CNT_W-1:0]     out_underflow_r;
  logic [CNT_W-1:0]     out_overflow_r;

  logic [MAG_W-1:0]     limit;
  logic [MAG_W-1:0]     mag;
  outcome_t             class_out;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CNT_W-1:0]     ram_wdata;
  logic [CNT_W-1:0]     ram_rdata;
  logic [CNT_W-1:0]     bin_next;

  // Configuration writes; the port always accepts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_bound_r   <= 1'b0;
      bins_in_use_r <= BIU_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ALL_BOUND:   all_bound_r   <= cfg_data[0];
        CFG_BINS_IN_USE: bins_in_use_r <= cfg_data[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming item; bins in use saturate at the store depth.
  assign limit = (MAG_W'(bins_in_use_r) > BINS_MAG) ? BINS_MAG : MAG_W'(bins_in_use_r);
  assign mag   = in_channel[MAG_W-1:0];

  always_comb begin
    if (!all_bound_r || !in_value_valid) begin
      class_out = OUT_IGNORED;
    end else if (in_channel[CH_W-1]) begin
      class_out = OUT_UNDER;
    end else if (mag >= limit) begin
      class_out = OUT_OVER;
    end else begin
      class_out = OUT_BIN;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_outcome_r <= class_out;
      item_addr_r    <= mag[AW-1:0];
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign status.clear_last = (clr_addr_r == LAST_ADDR);

  // Bin store write-back: zero during the clearing pass, else the bumped count.
  assign bin_next  = ram_rdata + CNT_W'(1);
  assign ram_we    = cmd.clear_wr || (cmd.update && (item_outcome_r == OUT_BIN));
  assign ram_waddr = cmd.clear_wr ? clr_addr_r : item_addr_r;
  assign ram_wdata = cmd.clear_wr ? '0 : bin_next;

  hbi_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (item_addr_r),
    .rd_data (ram_rdata)
  );

  // Underflow and overflow counters, wrapping at 32 bits.
  assign underflow_nxt = underflow_r +
                         CNT_W'(cmd.update && (item_outcome_r == OUT_UNDER));
  assign overflow_nxt  = overflow_r +
                         CNT_W'(cmd.update && (item_outcome_r == OUT_OVER));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      underflow_r <= '0;
      overflow_r  <= '0;
    end else begin
      underflow_r <= underflow_nxt;
      overflow_r  <= overflow_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_outcome_r   <= item_outcome_r;
      out_bin_count_r <= (item_outcome_r == OUT_BIN) ? bin_next : '0;
      out_underflow_r <= underflow_nxt;
      out_overflow_r  <= overflow_nxt;
    end
  end

  assign out_outcome         = out_outcome_r;
  assign out_bin_count       = out_bin_count_r;
  assign out_underflow_total = out_underflow_r;
  assign out_overflow_total  = out_overflow_r;

endmodule
